@@ rtl/core/sdspi_pkg.sv @@
package sdspi_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int WAKE_BYTES   = 15;
    localparam int SKIP_BYTES   = 10;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [7:0] RETRY_RESET = 8'd200;

    typedef enum logic [2:0] {
        KIND_INIT  = 3'd0,
        KIND_READ  = 3'd1,
        KIND_WRITE = 3'd2,
        KIND_BYTE  = 3'd3,
        KIND_WDATA = 3'd4
    } in_kind_t;

    typedef enum logic [1:0] {
        RES_XFER  = 2'd0,
        RES_READ  = 2'd1,
        RES_WREQ  = 2'd2,
        RES_DONE  = 2'd3
    } res_kind_t;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_CMD0     = 3'd1;
    localparam logic [2:0] ST_CMD1     = 3'd2;
    localparam logic [2:0] ST_RD       = 3'd3;
    localparam logic [2:0] ST_REJECT   = 3'd4;
    localparam logic [2:0] ST_WR       = 3'd5;

    typedef enum logic [2:0] {
        CMD_GO  = 3'd0,
        CMD_IF  = 3'd1,
        CMD_OP  = 3'd2,
        CMD_OCR = 3'd3,
        CMD_RD  = 3'd4,
        CMD_WR  = 3'd5
    } cmd_t;

    // classified word handed from front to back
    typedef struct packed {
        in_kind_t    kind;
        logic [31:0] sector_address;
        logic [7:0]  data_byte;
    } word_t;

    // one result word
    typedef struct packed {
        res_kind_t   result_kind;
        logic [7:0]  tx_byte;
        logic        chip_select;
        logic [7:0]  read_byte;
        logic [2:0]  status;
        logic [7:0]  card_response;
        logic        last;
    } res_t;

    function automatic logic [7:0] frame_byte(cmd_t c, logic [2:0] k, logic [31:0] arg);
        logic [7:0] b;
        b = 8'h00;
        if ((c == CMD_RD || c == CMD_WR) && k >= 3'd1 && k <= 3'd4) begin
            unique case (k)
                3'd1: b = arg[31:24];
                3'd2: b = arg[23:16];
                3'd3: b = arg[15:8];
                default: b = arg[7:0];
            endcase
        end else begin
            case (c)
                CMD_GO: begin
                    case (k)
                        3'd0: b = 8'h40;
                        3'd5: b = 8'h95;
                        default: b = 8'h00;
                    endcase
                end
                CMD_IF: begin
                    case (k)
                        3'd0: b = 8'h48;
                        3'd3: b = 8'h01;
                        3'd4: b = 8'haa;
                        3'd5: b = 8'h87;
                        default: b = 8'h00;
                    endcase
                end
                CMD_OP: begin
                    case (k)
                        3'd0: b = 8'h41;
                        3'd1: b = 8'h40;
                        3'd5: b = 8'hff;
                        default: b = 8'h00;
                    endcase
                end
                CMD_OCR: b = (k == 3'd0) ? 8'h7a : 8'h00;
                CMD_RD: b = (k == 3'd0) ? 8'h51 : 8'hff;
                default: b = (k == 3'd0) ? 8'h58 : 8'hff;
            endcase
        end
        return b;
    endfunction

endpackage

@@ rtl/core/sdspi_front.sv @@
module sdspi_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          kind,
    input  logic [31:0]         sector_address,
    input  logic [7:0]          data_byte,
    output logic                q_valid,
    input  logic                q_pop,
    output sdspi_pkg::word_t    q_word
);

    localparam int AW = $clog2(sdspi_pkg::QUEUE_DEPTH);

    sdspi_pkg::word_t   mem_reg [sdspi_pkg::QUEUE_DEPTH];
    logic [AW-1:0]      wr_reg, rd_reg;
    logic [AW:0]        cnt_reg;
    logic               push;
    logic               legal;

    // kinds above write data carry nothing and are dropped here
    assign legal    = (kind <= 3'(sdspi_pkg::KIND_WDATA));
    assign in_stall = (cnt_reg == (AW+1)'(sdspi_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall && legal;
    assign q_valid  = (cnt_reg != '0);
    assign q_word   = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (q_pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= '{kind: sdspi_pkg::in_kind_t'(kind),
                                 sector_address: sector_address,
                                 data_byte: data_byte};
    end

endmodule

@@ rtl/core/sdspi_back.sv @@
module sdspi_back #(
    parameter int WAKE_BYTES = sdspi_pkg::WAKE_BYTES,
    parameter int SKIP_BYTES = sdspi_pkg::SKIP_BYTES
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_wdata,
    input  logic             q_valid,
    output logic             q_pop,
    input  sdspi_pkg::word_t q_word,
    output logic             out_valid,
    input  logic             out_stall,
    output sdspi_pkg::res_t  out_res
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_WAKE, PH_CPRE, PH_CBYTE, PH_CPOLL, PH_TRAIL, PH_OCR,
        PH_RTOKEN, PH_RDATA, PH_RCRC, PH_WSKIP, PH_WTOKEN, PH_WREQ,
        PH_WDATA, PH_WCRC, PH_WRESP, PH_WBUSY
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [9:0]      bc_reg, bc_next;
    logic [7:0]      poll_reg, poll_next;
    logic [7:0]      retry_reg, retry_next;
    logic [7:0]      ver_reg, ver_next;
    logic            blk_reg, blk_next;
    logic [31:0]     arg_reg, arg_next;
    logic            sel_reg, sel_next;
    sdspi_pkg::cmd_t cmd_reg, cmd_next;
    logic [7:0]      resp_reg, resp_next;
    logic [7:0]      limit_reg;

    // up to two results per word, held in a small output buffer
    sdspi_pkg::res_t buf_reg [3];
    logic [1:0]      bcnt_reg, bhead_reg;
    sdspi_pkg::res_t gen [3];
    logic [1:0]      ngen;

    logic            take;
    sdspi_pkg::word_t w;
    logic [7:0]      d;
    logic            drain;

    assign w = q_word;
    assign d = q_word.data_byte;
    // only accept a new word once earlier results are gone or leaving
    assign drain = (bcnt_reg == 2'd0) ||
                   (bcnt_reg == 2'd1 && !out_stall);
    assign take  = q_valid && drain;
    assign q_pop = take;

    assign out_valid = (bcnt_reg != 2'd0);
    assign out_res   = buf_reg[bhead_reg];

    always_comb
    begin
        logic [7:0] rc;
        logic       ok;
        logic [31:0] a;
        phase_next = phase_reg;
        bc_next    = bc_reg;
        poll_next  = poll_reg;
        retry_next = retry_reg;
        ver_next   = ver_reg;
        blk_next   = blk_reg;
        arg_next   = arg_reg;
        sel_next   = sel_reg;
        cmd_next   = cmd_reg;
        resp_next  = resp_reg;
        ngen       = 2'd0;
        rc = '0;
        ok = 1'b0;
        a  = '0;
        for (int i = 0; i < 3; i++)
            gen[i] = '0;

        if (take)
        begin
            case (w.kind)
                sdspi_pkg::KIND_INIT, sdspi_pkg::KIND_READ, sdspi_pkg::KIND_WRITE:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        if (w.kind == sdspi_pkg::KIND_INIT)
                        begin
                            phase_next = PH_WAKE;
                            bc_next = 10'd1;
                            sel_next = 1'b1;
                            gen[0] = '{sdspi_pkg::RES_XFER, 8'hff, 1'b1, 8'h0,
                                       sdspi_pkg::ST_OK, 8'h0, 1'b0};
                            ngen = 2'd1;
                        end
                        else
                        begin
                            a = w.sector_address;
                            if (ver_reg == 8'h05 || !blk_reg)
                                a = {a[22:0], 9'd0};
                            arg_next = a;
                            retry_next = '0;
                            cmd_next = (w.kind == sdspi_pkg::KIND_READ) ?
                                       sdspi_pkg::CMD_RD : sdspi_pkg::CMD_WR;
                            phase_next = PH_CPRE;
                            sel_next = 1'b1;
                            gen[0] = '{sdspi_pkg::RES_XFER, 8'hff, 1'b1, 8'h0,
                                       sdspi_pkg::ST_OK, 8'h0, 1'b0};
                            ngen = 2'd1;
                        end
                    end
                end
                sdspi_pkg::KIND_WDATA:
                begin
                    if (phase_reg == PH_WREQ)
                    begin
                        phase_next = PH_WDATA;
                        sel_next = 1'b0;
                        gen[0] = '{sdspi_pkg::RES_XFER, d, 1'b0, 8'h0,
                                   sdspi_pkg::ST_OK, 8'h0, 1'b0};
                        ngen = 2'd1;
                    end
                end
                sdspi_pkg::KIND_BYTE:
                begin
                    unique case (phase_reg)
                        PH_IDLE, PH_WREQ: ;
                        PH_WAKE:
                        begin
                            if (bc_reg < 10'(WAKE_BYTES))
                            begin
                                bc_next = bc_reg + 10'd1;
                                rc = 8'hff;
                                ok = 1'b1;
                                sel_next = 1'b1;
                            end
                            else
                            begin
                                retry_next = '0;
                                cmd_next = sdspi_pkg::CMD_GO;
                                phase_next = PH_CPRE;
                                rc = 8'hff;
                                ok = 1'b1;
                                sel_next = 1'b1;
                            end
                        end
                        PH_CPRE:
                        begin
                            phase_next = PH_CBYTE;
                            bc_next = 10'd1;
                            sel_next = 1'b0;
                            rc = sdspi_pkg::frame_byte(cmd_reg, 3'd0, arg_reg);
                            ok = 1'b1;
                        end
                        PH_CBYTE:
                        begin
                            sel_next = 1'b0;
                            ok = 1'b1;
                            if (bc_reg < 10'd6)
                            begin
                                rc = sdspi_pkg::frame_byte(cmd_reg, bc_reg[2:0], arg_reg);
                                bc_next = bc_reg + 10'd1;
                            end
                            else
                            begin
                                phase_next = PH_CPOLL;
                                poll_next = '0;
                                rc = 8'hff;
                            end
                        end
                        PH_CPOLL:
                        begin
                            poll_next = poll_reg + 8'd1;
                            if (d == 8'hff && (poll_reg + 8'd1) < limit_reg)
                            begin
                                sel_next = 1'b0;
                                rc = 8'hff;
                                ok = 1'b1;
                            end
                            else
                            begin
                                resp_next = d;
                                if (cmd_reg == sdspi_pkg::CMD_IF)
                                begin
                                    ver_next = d;
                                    phase_next = PH_TRAIL;
                                    sel_next = 1'b1;
                                    rc = 8'hff;
                                    ok = 1'b1;
                                end
                                else if (cmd_reg == sdspi_pkg::CMD_OCR)
                                begin
                                    phase_next = PH_OCR;
                                    bc_next = '0;
                                    sel_next = 1'b0;
                                    rc = 8'hff;
                                    ok = 1'b1;
                                end
                                else
                                begin
                                    retry_next = retry_reg + 8'd1;
                                    if (retry_reg + 8'd1 == limit_reg)
                                    begin
                                        phase_next = PH_IDLE;
                                        gen[0] = '{sdspi_pkg::RES_DONE, 8'h0, sel_reg, 8'h0,
                                            (cmd_reg == sdspi_pkg::CMD_GO) ? sdspi_pkg::ST_CMD0 :
                                            (cmd_reg == sdspi_pkg::CMD_OP) ? sdspi_pkg::ST_CMD1 :
                                            (cmd_reg == sdspi_pkg::CMD_RD) ? sdspi_pkg::ST_RD :
                                            sdspi_pkg::ST_WR, d, 1'b0};
                                        ngen = 2'd1;
                                    end
                                    else if (d == ((cmd_reg == sdspi_pkg::CMD_GO) ?
                                                   8'h01 : 8'h00))
                                    begin
                                        ok = 1'b1;
                                        rc = 8'hff;
                                        if (cmd_reg == sdspi_pkg::CMD_RD)
                                        begin
                                            phase_next = PH_RTOKEN;
                                            sel_next = 1'b0;
                                        end
                                        else if (cmd_reg == sdspi_pkg::CMD_WR)
                                        begin
                                            phase_next = PH_WSKIP;
                                            bc_next = '0;
                                            sel_next = 1'b0;
                                        end
                                        else
                                        begin
                                            phase_next = PH_TRAIL;
                                            sel_next = 1'b1;
                                        end
                                    end
                                    else
                                    begin
                                        phase_next = PH_CPRE;
                                        sel_next = 1'b1;
                                        rc = 8'hff;
                                        ok = 1'b1;
                                    end
                                end
                            end
                        end
                        PH_TRAIL:
                        begin
                            if (cmd_reg == sdspi_pkg::CMD_GO || cmd_reg == sdspi_pkg::CMD_IF ||
                                cmd_reg == sdspi_pkg::CMD_OCR)
                            begin
                                retry_next = '0;
                                cmd_next = (cmd_reg == sdspi_pkg::CMD_GO) ? sdspi_pkg::CMD_IF :
                                           (cmd_reg == sdspi_pkg::CMD_IF) ? sdspi_pkg::CMD_OCR :
                                           sdspi_pkg::CMD_OP;
                                phase_next = PH_CPRE;
                                sel_next = 1'b1;
                                rc = 8'hff;
                                ok = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                gen[0] = '{sdspi_pkg::RES_DONE, 8'h0, sel_reg, 8'h0,
                                           sdspi_pkg::ST_OK, resp_reg, 1'b0};
                                ngen = 2'd1;
                            end
                        end
                        PH_OCR:
                        begin
                            if (bc_reg == '0)
                                blk_next = d[6];
                            bc_next = bc_reg + 10'd1;
                            rc = 8'hff;
                            ok = 1'b1;
                            if (bc_reg + 10'd1 < 10'd4)
                                sel_next = 1'b0;
                            else
                            begin
                                phase_next = PH_TRAIL;
                                sel_next = 1'b1;
                            end
                        end
                        PH_RTOKEN:
                        begin
                            if (d == 8'hfe)
                            begin
                                phase_next = PH_RDATA;
                                bc_next = '0;
                            end
                            sel_next = 1'b0;
                            rc = 8'hff;
                            ok = 1'b1;
                        end
                        PH_RDATA:
                        begin
                            gen[0] = '{sdspi_pkg::RES_READ, 8'h0, sel_reg, d,
                                       sdspi_pkg::ST_OK, 8'h0, 1'b0};
                            ngen = 2'd1;
                            bc_next = bc_reg + 10'd1;
                            if (bc_reg == 10'(sdspi_pkg::SECTOR_BYTES - 1))
                            begin
                                phase_next = PH_RCRC;
                                bc_next = '0;
                            end
                            sel_next = 1'b0;
                            rc = 8'hff;
                            ok = 1'b1;
                        end
                        PH_RCRC:
                        begin
                            bc_next = bc_reg + 10'd1;
                            rc = 8'hff;
                            ok = 1'b1;
                            if (bc_reg + 10'd1 < 10'd2)
                                sel_next = 1'b0;
                            else
                            begin
                                phase_next = PH_TRAIL;
                                sel_next = 1'b1;
                            end
                        end
                        PH_WSKIP:
                        begin
                            bc_next = bc_reg + 10'd1;
                            sel_next = 1'b0;
                            ok = 1'b1;
                            if (bc_reg + 10'd1 < 10'(SKIP_BYTES))
                                rc = 8'hff;
                            else
                            begin
                                phase_next = PH_WTOKEN;
                                rc = 8'hfe;
                            end
                        end
                        PH_WTOKEN:
                        begin
                            bc_next = '0;
                            phase_next = PH_WREQ;
                            gen[0] = '{sdspi_pkg::RES_WREQ, 8'h0, sel_reg, 8'h0,
                                       sdspi_pkg::ST_OK, 8'h0, 1'b0};
                            ngen = 2'd1;
                        end
                        PH_WDATA:
                        begin
                            bc_next = bc_reg + 10'd1;
                            // bytes count from zero, so the last sector byte sits one below the sector size
                            if (bc_reg < 10'(sdspi_pkg::SECTOR_BYTES - 1))
                            begin
                                phase_next = PH_WREQ;
                                gen[0] = '{sdspi_pkg::RES_WREQ, 8'h0, sel_reg, 8'h0,
                                           sdspi_pkg::ST_OK, 8'h0, 1'b0};
                                ngen = 2'd1;
                            end
                            else
                            begin
                                phase_next = PH_WCRC;
                                bc_next = '0;
                                sel_next = 1'b0;
                                rc = 8'hff;
                                ok = 1'b1;
                            end
                        end
                        PH_WCRC:
                        begin
                            bc_next = bc_reg + 10'd1;
                            if (bc_reg + 10'd1 >= 10'd2)
                                phase_next = PH_WRESP;
                            sel_next = 1'b0;
                            rc = 8'hff;
                            ok = 1'b1;
                        end
                        PH_WRESP:
                        begin
                            if (d[4:0] != 5'h05)
                            begin
                                sel_next = 1'b1;
                                phase_next = PH_IDLE;
                                gen[0] = '{sdspi_pkg::RES_DONE, 8'h0, 1'b1, 8'h0,
                                           sdspi_pkg::ST_REJECT, resp_reg, 1'b0};
                                ngen = 2'd1;
                            end
                            else
                            begin
                                phase_next = PH_WBUSY;
                                sel_next = 1'b0;
                                rc = 8'hff;
                                ok = 1'b1;
                            end
                        end
                        PH_WBUSY:
                        begin
                            rc = 8'hff;
                            ok = 1'b1;
                            if (d == 8'hff)
                            begin
                                phase_next = PH_TRAIL;
                                sel_next = 1'b1;
                            end
                            else
                                sel_next = 1'b0;
                        end
                        default: ;
                    endcase
                    // the transfer always comes after any other result of this word
                    if (ok)
                    begin
                        gen[ngen] = '{sdspi_pkg::RES_XFER, rc, sel_next, 8'h0,
                                      sdspi_pkg::ST_OK, 8'h0, 1'b0};
                        ngen = ngen + 2'd1;
                    end
                end
                default: ;
            endcase
            if (ngen != 2'd0)
                gen[ngen - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bc_reg    <= '0;
            poll_reg  <= '0;
            retry_reg <= '0;
            ver_reg   <= '0;
            blk_reg   <= 1'b0;
            arg_reg   <= '0;
            sel_reg   <= 1'b1;
            cmd_reg   <= sdspi_pkg::CMD_GO;
            resp_reg  <= '0;
            limit_reg <= sdspi_pkg::RETRY_RESET;
            bcnt_reg  <= '0;
            bhead_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            bc_reg    <= bc_next;
            poll_reg  <= poll_next;
            retry_reg <= retry_next;
            ver_reg   <= ver_next;
            blk_reg   <= blk_next;
            arg_reg   <= arg_next;
            sel_reg   <= sel_next;
            cmd_reg   <= cmd_next;
            resp_reg  <= resp_next;
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (take)
            begin
                bcnt_reg  <= ngen;
                bhead_reg <= '0;
            end
            else if (out_valid && !out_stall)
            begin
                bcnt_reg  <= bcnt_reg - 2'd1;
                bhead_reg <= bhead_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            for (int i = 0; i < 3; i++)
                buf_reg[i] <= gen[i];
    end

endmodule

@@ rtl/core/sd_card_spi_host_sequencer_top.sv @@
// sd card host sequencer, spi mode, one byte exchange per word
//
// input channel: in_valid / in_stall carry kind, sector_address, data_byte.
// kinds: start init, start read, start write, byte received, write data byte.
// output channel: out_valid / out_stall carry one result word per handshake:
// spi transfer, read byte to host, request write byte or done; last marks the
// final result word caused by an input word.
// every transfer word must be answered by one byte-received input word.
// config: cfg_we / cfg_wdata write retry_limit (reset 200); write only when idle.
//
// a four-deep word queue sits behind the input port, so input words keep
// landing while the result side stalls. the sequencer takes one word a
// cycle when its output buffer is empty or holds a last word leaving now;
// a word gives 0 to 2 result words, so while out_stall is low the sustained rate
// is one input word per cycle for single-result words, else one per result word.
// accepted words are registered in the queue, their results in the output buffer.
// reset: card deselected, sequencer idle, queue and output buffer empty.
// on out_stall the current result word holds; queue fills, then in_stall rises
module sd_card_spi_host_sequencer_top #(
    parameter int WAKE_BYTES = sdspi_pkg::WAKE_BYTES,
    parameter int SKIP_BYTES = sdspi_pkg::SKIP_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [31:0] sector_address,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [7:0]  tx_byte,
    output logic        chip_select,
    output logic [7:0]  read_byte,
    output logic [2:0]  status,
    output logic [7:0]  card_response,
    output logic        last
);

    logic             q_valid;
    logic             q_pop;
    sdspi_pkg::word_t q_word;
    sdspi_pkg::res_t  res;

    // front: accepts and queues words
    sdspi_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .sector_address (sector_address),
        .data_byte      (data_byte),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_word         (q_word)
    );

    // back: sequencer plus result buffer
    sdspi_back #(
        .WAKE_BYTES (WAKE_BYTES),
        .SKIP_BYTES (SKIP_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_word    (q_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (res)
    );

    assign result_kind   = res.result_kind;
    assign tx_byte       = res.tx_byte;
    assign chip_select   = res.chip_select;
    assign read_byte     = res.read_byte;
    assign status        = res.status;
    assign card_response = res.card_response;
    assign last          = res.last;

endmodule

@@ rtl/core/sdspi_checker.sv @@
module sdspi_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] result_kind,
    input logic [7:0] tx_byte,
    input logic [7:0] read_byte,
    input logic [2:0] status,
    input logic       last
);

    // stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(last))
        else $error("stalled result changed");

    // done is always the final word of its run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == sdspi_pkg::RES_DONE |-> last)
        else $error("done without last");

    // a read byte word never ends a run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == sdspi_pkg::RES_READ |-> !last)
        else $error("read byte marked last");

    // status only in done words
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != sdspi_pkg::RES_DONE |-> status == sdspi_pkg::ST_OK)
        else $error("status outside done");

    // read byte field clear outside read words
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != sdspi_pkg::RES_READ |-> read_byte == 8'd0)
        else $error("read byte outside read");

endmodule

bind sd_card_spi_host_sequencer_top sdspi_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .tx_byte     (tx_byte),
    .read_byte   (read_byte),
    .status      (status),
    .last        (last)
);
